FILE: src/u8u16_pkg.sv
package u8u16_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned AccW   = 21;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  localparam logic [AccW-1:0]  SuppBase = 21'h10000;
  localparam logic [UnitW-1:0] HiBase   = 16'hD800;
  localparam logic [UnitW-1:0] LoBase   = 16'hDC00;

  // work handed from the decoder to the emitter
  typedef struct packed {
    logic            pair;  // emit high and low surrogate from val
    logic            bad;   // invalid lead byte
    logic [AccW-1:0] val;   // code unit, or code point minus 0x10000 for a pair
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: src/utf8_to_utf16_decoder_unit.sv
// utf8 to utf16 transcoder
// slave stream: one utf-8 byte per transfer on s_axis_tdata
// master stream: one utf-16 code unit per transfer on m_axis_tdata, tlast marks
// the final unit caused by one input byte, tuser flags an invalid lead byte
// (code unit zero, byte dropped)
// an ascii byte or the last byte of a sequence passes through the command queue
// and the output register; lead and middle bytes of a sequence give no output
// a 4-byte sequence gives a surrogate pair: high unit, then low unit from lo_q
// throughput: one byte per cycle in while the queue is not full; the emitter
// gives one unit per cycle while the receiver is ready, and a four-entry
// command queue absorbs the extra unit of surrogate pairs
// when the receiver stalls, the output register holds and the queue fills;
// s_axis_tready drops only once the queue is full
// reset clears the open sequence, the queue and the output register
module utf8_to_utf16_decoder_unit
  import u8u16_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,   // [7:0] byte_in
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [UnitW-1:0] m_axis_tdata,   // [15:0] code_unit
  output logic             m_axis_tlast,   // last_unit
  output logic             m_axis_tuser    // [0] bad_lead
);

  q_stat_t q_stat;
  logic    push, pop;
  cmd_t    cmd_in, cmd_out;

  u8u16_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  u8u16_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (pop),
    .cmd_o  (cmd_out),
    .stat_o (q_stat)
  );

  u8u16_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_out),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

FILE: src/u8u16_front.sv
module u8u16_front
  import u8u16_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,  // byte_in
  input  q_stat_t          q_stat_i,
  output logic             push_o,
  output cmd_t             cmd_o
);

  typedef enum logic [2:0] {
    LeadAscii,
    LeadTwo,
    LeadThree,
    LeadFour,
    LeadBad
  } lead_e;

  logic [1:0]      pend_q, pend_d;
  logic [1:0]      len_q, len_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [AccW-1:0] acc_shift;
  lead_e           lead;
  logic            accept;

  assign s_axis_tready = !q_stat_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign acc_shift     = {acc_q[AccW-7:0], s_axis_tdata[5:0]};

  always_comb begin
    if (!s_axis_tdata[7]) begin
      lead = LeadAscii;
    end else if (s_axis_tdata[7:5] == 3'b110) begin
      lead = LeadTwo;
    end else if (s_axis_tdata[7:4] == 4'b1110) begin
      lead = LeadThree;
    end else if (s_axis_tdata[7:3] == 5'b11110) begin
      lead = LeadFour;
    end else begin
      lead = LeadBad;
    end
  end

  always_comb begin
    pend_d = pend_q;
    len_d  = len_q;
    acc_d  = acc_q;
    push_o = 1'b0;
    cmd_o  = '0;
    if (accept) begin
      if (pend_q == 2'd0) begin
        case (lead)
          LeadAscii: begin
            push_o    = 1'b1;
            cmd_o.val = AccW'(s_axis_tdata);
          end
          LeadTwo: begin
            acc_d  = AccW'(s_axis_tdata[4:0]);
            len_d  = 2'd1;
            pend_d = 2'd1;
          end
          LeadThree: begin
            acc_d  = AccW'(s_axis_tdata[3:0]);
            len_d  = 2'd2;
            pend_d = 2'd2;
          end
          LeadFour: begin
            acc_d  = AccW'(s_axis_tdata[2:0]);
            len_d  = 2'd3;
            pend_d = 2'd3;
          end
          default: begin
            push_o    = 1'b1;
            cmd_o.bad = 1'b1;
          end
        endcase
      end else begin
        // continuation bits are taken without checking the top two bits
        acc_d  = acc_shift;
        pend_d = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          push_o = 1'b1;
          if (len_q == 2'd3) begin
            cmd_o.pair = 1'b1;
            cmd_o.val  = acc_shift - SuppBase;
          end else begin
            cmd_o.val = AccW'(acc_shift[UnitW-1:0]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      len_q  <= '0;
      acc_q  <= '0;
    end else begin
      pend_q <= pend_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
    end
  end

endmodule

FILE: src/u8u16_queue.sv
module u8u16_queue
  import u8u16_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    cmd_i,
  input  logic    pop_i,
  output cmd_t    cmd_o,
  output q_stat_t stat_o
);

  cmd_t         mem_q [QDepth];
  logic [QAw-1:0] wr_q, rd_q;
  logic [QAw:0]   cnt_q;
  logic           do_push, do_pop;

  assign stat_o.full  = (cnt_q == (QAw+1)'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QAw'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QAw'(1);
      end
      cnt_q <= cnt_q + (QAw+1)'(do_push) - (QAw+1)'(do_pop);
    end
  end

endmodule

FILE: src/u8u16_back.sv
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  q_stat_t          q_stat_i,
  output logic             pop_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [UnitW-1:0] m_axis_tdata,  // code_unit
  output logic             m_axis_tlast,  // last_unit
  output logic             m_axis_tuser   // bad_lead
);

  logic             vld_q;
  logic [UnitW-1:0] unit_q;
  logic             last_q, bad_q;
  logic             lo_pend_q;
  logic [UnitW-1:0] lo_q;
  logic             load;
  logic [UnitW-1:0] hi_unit, lo_unit;

  assign load    = !vld_q || m_axis_tready;
  assign pop_o   = load && !lo_pend_q && !q_stat_i.empty;
  assign hi_unit = HiBase + UnitW'(cmd_i.val[AccW-1:10]);
  assign lo_unit = LoBase | UnitW'(cmd_i.val[9:0]);

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = unit_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      lo_pend_q <= 1'b0;
      unit_q    <= '0;
      last_q    <= 1'b0;
      bad_q     <= 1'b0;
      lo_q      <= '0;
    end else if (load) begin
      if (lo_pend_q) begin
        // second transfer of a surrogate pair
        vld_q     <= 1'b1;
        unit_q    <= lo_q;
        last_q    <= 1'b1;
        bad_q     <= 1'b0;
        lo_pend_q <= 1'b0;
      end else if (!q_stat_i.empty) begin
        vld_q  <= 1'b1;
        bad_q  <= cmd_i.bad;
        if (cmd_i.pair) begin
          unit_q    <= hi_unit;
          last_q    <= 1'b0;
          lo_q      <= lo_unit;
          lo_pend_q <= 1'b1;
        end else begin
          unit_q <= cmd_i.val[UnitW-1:0];
          last_q <= 1'b1;
        end
      end else begin
        vld_q <= 1'b0;
      end
    end
  end

endmodule

FILE: bench/tb_utf8_to_utf16_decoder_unit.sv
module tb_utf8_to_utf16_decoder_unit
  import u8u16_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StreamBytes = 1750;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 8;

  // lead byte prefixes
  localparam logic [2:0] Lead2 = 3'b110;
  localparam logic [3:0] Lead3 = 4'b1110;
  localparam logic [4:0] Lead4 = 5'b11110;
  localparam logic [1:0] ContTag = 2'b10;

  typedef struct packed {
    logic [UnitW-1:0] code;
    logic             last;
    logic             bad;
  } utf16_unit_t;

  class utf16_unit_tracker;
    utf16_unit_t     expected_units[$];
    logic [1:0]      conts_left;
    logic [1:0]      seq_conts;
    logic [AccW-1:0] cp_acc;
    int unsigned     errors;

    function new();
      conts_left = '0;
      seq_conts  = '0;
      cp_acc     = '0;
      errors     = 0;
    endfunction

    function void push_unit(logic [UnitW-1:0] code, logic last, logic bad);
      utf16_unit_t u;
      u.code = code;
      u.last = last;
      u.bad  = bad;
      expected_units.insert(expected_units.size(), u);
    endfunction

    // called for every byte transfer on the input side
    function void note_byte(logic [ByteW-1:0] b);
      logic [AccW-1:0]  v;
      logic [UnitW-1:0] hi;
      logic [UnitW-1:0] lo;
      if (conts_left == 2'd0) begin
        if (!b[7]) begin
          push_unit({8'h00, b}, 1'b1, 1'b0);
        end else if (b[7:5] == Lead2) begin
          cp_acc     = AccW'(b[4:0]);
          seq_conts  = 2'd1;
          conts_left = 2'd1;
        end else if (b[7:4] == Lead3) begin
          cp_acc     = AccW'(b[3:0]);
          seq_conts  = 2'd2;
          conts_left = 2'd2;
        end else if (b[7:3] == Lead4) begin
          cp_acc     = AccW'(b[2:0]);
          seq_conts  = 2'd3;
          conts_left = 2'd3;
        end else begin
          push_unit('0, 1'b1, 1'b1);
        end
      end else begin
        // continuation bytes are taken by their low six bits, tag unchecked
        cp_acc     = {cp_acc[AccW-7:0], b[5:0]};
        conts_left = conts_left - 2'd1;
        if (conts_left == 2'd0) begin
          if (seq_conts == 2'd3) begin
            v  = cp_acc - SuppBase;
            hi = HiBase + {5'b0, v[20:10]};
            lo = LoBase + {6'b0, v[9:0]};
            push_unit(hi, 1'b0, 1'b0);
            push_unit(lo, 1'b1, 1'b0);
          end else begin
            push_unit(cp_acc[UnitW-1:0], 1'b1, 1'b0);
          end
        end
      end
    endfunction

    function void check_unit(logic [UnitW-1:0] code, logic last, logic bad);
      utf16_unit_t e;
      if (expected_units.size() == 0) begin
        $error("unexpected code unit %04h last %0b bad %0b", code, last, bad);
        errors++;
        return;
      end
      e = expected_units.pop_front();
      if (code !== e.code) begin
        $error("code_unit mismatch: expected %04h, actual %04h", e.code, code);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_unit mismatch: expected %0b, actual %0b", e.last, last);
        errors++;
      end
      if (bad !== e.bad) begin
        $error("bad_lead mismatch: expected %0b, actual %0b", e.bad, bad);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [ByteW-1:0] s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [UnitW-1:0] m_axis_tdata;
  logic             m_axis_tlast;
  logic             m_axis_tuser;

  utf16_unit_tracker tracker;
  int unsigned       bytes_sent;
  int unsigned       burst_left;
  int unsigned       idle_cycles;
  int unsigned       rx_mode;
  int unsigned       rx_phase_left;
  int unsigned       rx_tick;

  utf8_to_utf16_decoder_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // receiver backpressure: phases of always ready, coin flip, heavy stall, periodic
  initial begin
    rx_mode       = 0;
    rx_phase_left = 0;
    rx_tick       = 0;
  end

  always @(negedge clk_i) begin
    if (rx_phase_left == 0) begin
      rx_mode       = $urandom_range(0, 3);
      rx_phase_left = $urandom_range(10, 60);
    end else begin
      rx_phase_left--;
    end
    rx_tick++;
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 4) == 0);
      default: m_axis_tready <= (rx_tick % 3 != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_unit(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  initial idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("utf8_to_utf16_decoder_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= ByteW'($urandom);
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_units_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.expected_units.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] cont_byte();
    // mostly well-formed continuations, now and then any byte
    if ($urandom_range(0, 15) == 0) return ByteW'($urandom);
    return {ContTag, 6'($urandom)};
  endfunction

  task automatic send_random_chunk();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      send_byte({1'b0, 7'($urandom)});
    end else if (kind < 50) begin
      send_byte({Lead2, 5'($urandom)});
      send_byte(cont_byte());
    end else if (kind < 65) begin
      send_byte({Lead3, 4'($urandom)});
      repeat (2) send_byte(cont_byte());
    end else if (kind < 82) begin
      send_byte({Lead4, 3'($urandom)});
      repeat (3) send_byte(cont_byte());
    end else if (kind < 92) begin
      send_byte(ByteW'($urandom));
    end else begin
      // sequence cut short, the next lead byte gets swallowed as continuation
      n = $urandom_range(0, 2);
      send_byte({Lead4, 3'($urandom)});
      repeat (n) send_byte(cont_byte());
    end
  endtask

  initial begin
    logic [ByteW-1:0] directed_bytes[$];
    bit               paused;
    tracker    = new();
    bytes_sent = 0;
    burst_left = 0;
    paused     = 1'b0;
    directed_bytes = '{
      8'h00, 8'h7F,                 // ascii extremes
      8'h80, 8'hF8, 8'hFF,          // invalid leads
      8'hC2, 8'hA9,                 // two bytes
      8'hE2, 8'h82, 8'hAC,          // three bytes
      8'hF0, 8'h9F, 8'h98, 8'h80,   // surrogate pair
      8'hF7, 8'hBF, 8'hBF, 8'hBF,   // largest accumulator value
      8'hF0, 8'h80, 8'h80, 8'h80,   // overlong four-byte form wraps
      8'hC3, 8'hE2                  // lead byte consumed as continuation
    };

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    while (bytes_sent < StreamBytes) begin
      send_random_chunk();
      if (!paused && bytes_sent >= StreamBytes / 2) begin
        wait_units_drained();
        paused = 1'b1;
      end
    end

    wait_units_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (tracker.errors == 0 && tracker.expected_units.size() == 0) begin
      $display("utf8_to_utf16_decoder_unit verification clean");
    end else begin
      $display("utf8_to_utf16_decoder_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/u8u16_pkg.sv
src/u8u16_front.sv
src/u8u16_queue.sv
src/u8u16_back.sv
src/utf8_to_utf16_decoder_unit.sv
bench/tb_utf8_to_utf16_decoder_unit.sv
